@@ hdl/nta_pkg.sv @@
package nta_pkg;

   // Input actions
   localparam logic [1:0] ACTION_OBSERVE = 2'd0;
   localparam logic [1:0] ACTION_AGE_OUT = 2'd1;
   localparam logic [1:0] ACTION_QUERY   = 2'd2;

   // Result status codes
   localparam logic [2:0] STATUS_UPDATED  = 3'd0;
   localparam logic [2:0] STATUS_INSERTED = 3'd1;
   localparam logic [2:0] STATUS_DROPPED  = 3'd2;
   localparam logic [2:0] STATUS_FOUND    = 3'd3;
   localparam logic [2:0] STATUS_NONE     = 3'd4;

   // Configuration register indexes
   localparam logic CSR_MATCH_RADIUS = 1'b0;
   localparam logic CSR_AGE_LIMIT    = 1'b1;

   localparam logic [11:0] MATCH_RADIUS_RESET = 12'd180;
   localparam logic [31:0] AGE_LIMIT_RESET    = 32'd10000;
   localparam int          SLOT_FIELD_W       = 5;
   localparam int          COUNT_FIELD_W      = 6;
   localparam int          DIST_W             = 33;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] heading;
      logic [31:0]        stamp;
   } req_type;

   typedef struct packed {
      logic [2:0]                 status;
      logic [SLOT_FIELD_W-1:0]    slot;
      logic [DIST_W-1:0]          dist_sq;
      logic signed [15:0]         track_heading;
      logic [COUNT_FIELD_W-1:0]   removed_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] orient;
      logic [31:0] stamp;
   } track_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic commit;
   } scan_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

endpackage

@@ hdl/nta_ram.sv @@
module nta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/nta_scan.sv @@
module nta_scan #(
   parameter int MAX_TRACKS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nta_pkg::scan_ctl_type         ctl,
   input  nta_pkg::req_type              req_data,
   input  logic [$clog2(MAX_TRACKS)-1:0] rd_addr,
   input  nta_pkg::track_type            rd_data,
   input  logic [23:0]                   radius_sq,
   input  logic [31:0]                   age_limit,
   output logic                          busy,
   output logic                          wr_en,
   output logic [$clog2(MAX_TRACKS)-1:0] wr_addr,
   output nta_pkg::track_type            wr_data,
   output nta_pkg::rsp_type              result
);

   localparam int SLOT_W = $clog2(MAX_TRACKS);
   localparam int CNT_W  = $clog2(MAX_TRACKS + 1);

   nta_pkg::req_type item_ff;
   logic             valid_ff [MAX_TRACKS];

   // stage 1: memory read data
   logic              s1_vld_ff;
   logic [SLOT_W-1:0] s1_idx_ff;
   logic              s1_live;
   // stage A: differences
   logic              a_vld_ff;
   logic              a_live_ff;
   logic [SLOT_W-1:0] a_idx_ff;
   logic [15:0]       a_orient_ff;
   logic signed [16:0] a_dx_ff;
   logic signed [16:0] a_dy_ff;
   logic signed [16:0] dx_in;
   logic signed [16:0] dy_in;
   // stage B: squares
   logic              b_vld_ff;
   logic              b_live_ff;
   logic [SLOT_W-1:0] b_idx_ff;
   logic [15:0]       b_orient_ff;
   logic [31:0]       b_sqx_ff;
   logic [31:0]       b_sqy_ff;
   logic signed [33:0] sqx;
   logic signed [33:0] sqy;
   // accumulator
   logic [nta_pkg::DIST_W-1:0] dist_sum;
   logic                       best_found_ff;
   logic [nta_pkg::DIST_W-1:0] best_d_ff;
   logic [SLOT_W-1:0]          best_idx_ff;
   logic [15:0]                best_orient_ff;
   logic                       free_found_ff;
   logic [SLOT_W-1:0]          free_idx_ff;
   logic [CNT_W-1:0]           removed_ff;

   logic [31:0] age;
   logic        expire;
   logic        is_observe;
   logic        match;
   logic        insert;

   assign s1_live = valid_ff[s1_idx_ff];
   assign age     = item_ff.stamp - rd_data.stamp;
   assign expire  = s1_vld_ff && s1_live && (item_ff.action == nta_pkg::ACTION_AGE_OUT) &&
                    (age > age_limit);
   assign dx_in   = {rd_data.x[15], rd_data.x} - {item_ff.pos_x[15], item_ff.pos_x};
   assign dy_in   = {rd_data.y[15], rd_data.y} - {item_ff.pos_y[15], item_ff.pos_y};
   assign sqx     = a_dx_ff * a_dx_ff;
   assign sqy     = a_dy_ff * a_dy_ff;
   assign dist_sum = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
   assign busy    = s1_vld_ff || a_vld_ff || b_vld_ff;

   assign is_observe = (item_ff.action == nta_pkg::ACTION_OBSERVE);
   assign match      = best_found_ff && (best_d_ff < {9'd0, radius_sq});
   assign insert     = !match && free_found_ff;

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         item_ff <= req_data;
      end
      a_idx_ff    <= s1_idx_ff;
      a_orient_ff <= rd_data.orient;
      a_dx_ff     <= dx_in;
      a_dy_ff     <= dy_in;
      b_idx_ff    <= a_idx_ff;
      b_orient_ff <= a_orient_ff;
      b_sqx_ff    <= sqx[31:0];
      b_sqy_ff    <= sqy[31:0];
      if (ctl.issue) begin
         s1_idx_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TRACKS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         s1_vld_ff      <= 1'b0;
         a_vld_ff       <= 1'b0;
         a_live_ff      <= 1'b0;
         b_vld_ff       <= 1'b0;
         b_live_ff      <= 1'b0;
         best_found_ff  <= 1'b0;
         best_d_ff      <= '0;
         best_idx_ff    <= '0;
         best_orient_ff <= '0;
         free_found_ff  <= 1'b0;
         free_idx_ff    <= '0;
         removed_ff     <= '0;
      end else begin
         s1_vld_ff <= ctl.issue;
         a_vld_ff  <= s1_vld_ff;
         a_live_ff <= s1_live;
         b_vld_ff  <= a_vld_ff;
         b_live_ff <= a_live_ff;

         if (ctl.start) begin
            best_found_ff  <= 1'b0;
            best_d_ff      <= '0;
            best_idx_ff    <= '0;
            best_orient_ff <= '0;
            free_found_ff  <= 1'b0;
            free_idx_ff    <= '0;
            removed_ff     <= '0;
         end else begin
            // keep the lowest free slot seen
            if (s1_vld_ff && !s1_live && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= s1_idx_ff;
            end
            if (expire) begin
               valid_ff[s1_idx_ff] <= 1'b0;
               removed_ff          <= removed_ff + 1'b1;
            end
            // strict compare: ties keep the earlier slot
            if (b_vld_ff && b_live_ff && (!best_found_ff || (dist_sum < best_d_ff))) begin
               best_found_ff  <= 1'b1;
               best_d_ff      <= dist_sum;
               best_idx_ff    <= b_idx_ff;
               best_orient_ff <= b_orient_ff;
            end
         end

         if (ctl.commit && is_observe && insert) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   assign wr_en          = ctl.commit && is_observe && (match || free_found_ff);
   assign wr_addr        = match ? best_idx_ff : free_idx_ff;
   assign wr_data.x      = item_ff.pos_x;
   assign wr_data.y      = item_ff.pos_y;
   assign wr_data.orient = item_ff.heading;
   assign wr_data.stamp  = item_ff.stamp;

   always_comb begin
      result = '0;
      result.status = nta_pkg::STATUS_NONE;
      unique case (item_ff.action)
         nta_pkg::ACTION_OBSERVE: begin
            result.dist_sq = best_d_ff;
            if (match) begin
               result.status        = nta_pkg::STATUS_UPDATED;
               result.slot          = nta_pkg::SLOT_FIELD_W'(best_idx_ff);
               result.track_heading = item_ff.heading;
            end else if (free_found_ff) begin
               result.status        = nta_pkg::STATUS_INSERTED;
               result.slot          = nta_pkg::SLOT_FIELD_W'(free_idx_ff);
               result.track_heading = item_ff.heading;
            end else begin
               result.status        = nta_pkg::STATUS_DROPPED;
               result.slot          = nta_pkg::SLOT_FIELD_W'(best_idx_ff);
               result.track_heading = best_orient_ff;
            end
         end
         nta_pkg::ACTION_AGE_OUT: begin
            result.status        = nta_pkg::STATUS_FOUND;
            result.removed_count = nta_pkg::COUNT_FIELD_W'(removed_ff);
         end
         nta_pkg::ACTION_QUERY: begin
            if (best_found_ff) begin
               result.status        = nta_pkg::STATUS_FOUND;
               result.slot          = nta_pkg::SLOT_FIELD_W'(best_idx_ff);
               result.dist_sq       = best_d_ff;
               result.track_heading = best_orient_ff;
            end
         end
         default: begin
            result.status = nta_pkg::STATUS_NONE;
         end
      endcase
   end

   // a slot freed by age-out must no longer be marked valid after the expire
   assert property (@(posedge clock) disable iff (reset)
      expire |=> !valid_ff[$past(s1_idx_ff)])
      else $error("aged slot still valid");

endmodule

@@ hdl/nta_ctrl.sv @@
module nta_ctrl #(
   parameter int MAX_TRACKS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          out_free,
   input  logic                          scan_busy,
   output nta_pkg::scan_ctl_type         ctl,
   output logic [$clog2(MAX_TRACKS)-1:0] rd_addr
);

   localparam int                SLOT_W    = $clog2(MAX_TRACKS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TRACKS - 1);

   nta_pkg::state_type state_ff;
   nta_pkg::state_type state_in;
   logic [SLOT_W-1:0]  addr_ff;
   logic [SLOT_W-1:0]  addr_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nta_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = nta_pkg::ST_SCAN;
            end
         end
         nta_pkg::ST_SCAN: begin
            if (addr_ff == LAST_SLOT) begin
               state_in = nta_pkg::ST_DRAIN;
            end
         end
         nta_pkg::ST_DRAIN: begin
            if (!scan_busy) begin
               state_in = nta_pkg::ST_DECIDE;
            end
         end
         nta_pkg::ST_DECIDE: begin
            // hold the decision until the output register is free
            if (out_free) begin
               state_in = nta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nta_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == nta_pkg::ST_IDLE);
      ctl.start  = (state_ff == nta_pkg::ST_IDLE) && req_valid;
      ctl.issue  = (state_ff == nta_pkg::ST_SCAN);
      ctl.commit = (state_ff == nta_pkg::ST_DECIDE) && out_free;
      rd_addr    = addr_ff;
      addr_in    = addr_ff;
      if (ctl.issue) begin
         addr_in = (addr_ff == LAST_SLOT) ? '0 : addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nta_pkg::ST_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> (state_ff == nta_pkg::ST_SCAN) && (addr_ff == '0))
      else $error("scan did not start at slot zero");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == nta_pkg::ST_DECIDE) |-> !scan_busy)
      else $error("decision taken with reads in flight");

   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !scan_busy)
      else $error("new transaction accepted while pipeline busy");

endmodule

@@ hdl/nearest_track_association_table.sv @@
// Nearest-neighbor track table. Each transaction on req_ (observe, age out or
// query) is answered by exactly one transaction on rsp_. The track positions,
// headings and times live in one single-port-read track memory; per-slot valid
// bits sit in flip-flops and are cleared by reset. Every transaction reads the
// memory once per slot, one slot per cycle, through a three-stage distance
// pipeline, then decides and writes back once the result register is free.
// The next transaction is accepted while the previous result still waits on
// rsp_. Write csr_ registers only while the block is idle; csr_ready is
// always high.
module nearest_track_association_table #(
   parameter int MAX_TRACKS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nta_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nta_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [31:0]      csr_data
);

   localparam int SLOT_W  = $clog2(MAX_TRACKS);
   localparam int TRACK_W = $bits(nta_pkg::track_type);

   logic [11:0]           match_radius_ff;
   logic [31:0]           age_limit_ff;
   logic [23:0]           radius_sq_ff;
   logic                  rsp_valid_ff;
   nta_pkg::rsp_type      rsp_data_ff;
   nta_pkg::scan_ctl_type ctl;
   nta_pkg::rsp_type      result;
   nta_pkg::track_type    rd_data;
   nta_pkg::track_type    wr_data;
   logic [SLOT_W-1:0]     rd_addr;
   logic [SLOT_W-1:0]     wr_addr;
   logic                  wr_en;
   logic                  scan_busy;
   logic                  out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_radius_ff <= nta_pkg::MATCH_RADIUS_RESET;
         age_limit_ff    <= nta_pkg::AGE_LIMIT_RESET;
         radius_sq_ff    <= 24'(nta_pkg::MATCH_RADIUS_RESET) *
                            24'(nta_pkg::MATCH_RADIUS_RESET);
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               nta_pkg::CSR_MATCH_RADIUS: match_radius_ff <= csr_data[11:0];
               nta_pkg::CSR_AGE_LIMIT:    age_limit_ff    <= csr_data;
               default:                   age_limit_ff    <= age_limit_ff;
            endcase
         end
         radius_sq_ff <= match_radius_ff * match_radius_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_data_ff <= result;
      end
   end

   nta_ctrl #(
      .MAX_TRACKS (MAX_TRACKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .scan_busy (scan_busy),
      .ctl       (ctl),
      .rd_addr   (rd_addr)
   );

   nta_ram #(
      .WIDTH (TRACK_W),
      .DEPTH (MAX_TRACKS)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nta_scan #(
      .MAX_TRACKS (MAX_TRACKS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_data  (req_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .radius_sq (radius_sq_ff),
      .age_limit (age_limit_ff),
      .busy      (scan_busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .result    (result)
   );

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.commit))
      else $error("result raised without a commit");

endmodule
